// ----- sv/ttrd_pkg.sv -----
package ttrd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]  fragment_byte;
    logic        byte_valid;
    logic [4:0]  tls_type;
    logic [15:0] record_version;
    logic [15:0] record_length;
    logic        record_first;
    logic        record_end;
    logic        record_drop;
  } record_item_t;

  typedef enum logic [6:0] {
    PH_ETH  = 7'b0000001,
    PH_VLAN = 7'b0000010,
    PH_IP   = 7'b0000100,
    PH_TCP  = 7'b0001000,
    PH_RHDR = 7'b0010000,
    PH_FRAG = 7'b0100000,
    PH_SKIP = 7'b1000000
  } phase_t;

  localparam logic [15:0] ETH_TYPE_VLAN   = 16'h8100;
  localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETH_TYPE_HI_POS = 16'd12;
  localparam logic [15:0] ETH_TYPE_LO_POS = 16'd13;
  localparam logic [15:0] VLAN_TYPE_HI_POS = 16'd16;
  localparam logic [15:0] VLAN_TYPE_LO_POS = 16'd17;
  localparam logic [15:0] IP_START_PLAIN  = 16'd14;
  localparam logic [15:0] IP_START_VLAN   = 16'd18;
  localparam logic [15:0] IP_PROTO_POS    = 16'd9;
  localparam logic [15:0] TCP_OFFSET_POS  = 16'd12;
  localparam logic [15:0] HDR_MIN_LAST    = 16'd19;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [3:0]  HDR_MIN_WORDS   = 4'd5;
  localparam logic [7:0]  TLS_TYPE_MIN    = 8'd20;
  localparam logic [7:0]  TLS_TYPE_MAX    = 8'd23;
  localparam logic [2:0]  RHDR_LAST_COUNT = 3'd4;

endpackage

// ----- sv/tcp_tls_record_deframer_core.sv -----
// TCP/TLS record deframer.
// frame_* channel: one Ethernet frame byte per transfer, packet_last on the
// final byte. Untagged or single-VLAN IPv4/TCP frames are parsed; the TCP
// payload is cut into TLS records and each fragment byte goes out on the
// record_* channel tagged with type, version and length. Empty records give
// one result without data; a record cut by the frame end is marked drop.
// Throughput: one byte per cycle while frame_stall is low. Each byte is
// decoded by counters and compares against the parse state in the cycle of
// its transfer; its result (if any) is registered for the record_* channel.
// Stall: the output register holds a stalled result; one more result lands
// in a skid register, and frame_stall rises while the skid register is full.
// Reset clears the parse state and empties both result registers; the
// first frame byte is taken in the cycle after rst falls.
module tcp_tls_record_deframer_core #(
  parameter int MAX_PACKET_BYTES = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_stall,
  input  ttrd_pkg::frame_item_t frame_item,
  output logic                  record_valid,
  input  logic                  record_stall,
  output ttrd_pkg::record_item_t record_item
);

  ttrd_pkg::phase_t parse_phase, parse_phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] ether_type, ether_type_next;
  logic [15:0] layer_start, layer_start_next;
  logic [5:0]  layer_header_length, layer_header_length_next;
  logic [31:0] record_header_bytes, record_header_bytes_next;
  logic [2:0]  record_header_count, record_header_count_next;
  logic [15:0] fragment_remaining, fragment_remaining_next;
  logic [4:0]  record_type, record_type_next;

  ttrd_pkg::record_item_t skid_item;
  logic                   skid_valid;
  ttrd_pkg::record_item_t result;

  logic        accept;
  logic        overlong;
  logic [15:0] rel;
  logic [16:0] rel_inc;
  logic [7:0]  b;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_valid, emit_first, emit_end, emit_drop;
  logic [31:0] hdr_shift;

  assign frame_stall = skid_valid;
  assign accept      = frame_valid && !frame_stall;
  assign b           = frame_item.data_byte;
  assign rel         = byte_position - layer_start;
  assign rel_inc     = {1'b0, rel} + 17'd1;
  assign overlong    = byte_position >= 16'(MAX_PACKET_BYTES);
  assign hdr_shift   = {record_header_bytes[23:0], b};

  always_comb begin
    parse_phase_next         = parse_phase;
    byte_position_next       = byte_position;
    ether_type_next          = ether_type;
    layer_start_next         = layer_start;
    layer_header_length_next = layer_header_length;
    record_header_bytes_next = record_header_bytes;
    record_header_count_next = record_header_count;
    fragment_remaining_next  = fragment_remaining;
    record_type_next         = record_type;
    emit       = 1'b0;
    emit_byte  = 8'd0;
    emit_valid = 1'b0;
    emit_first = 1'b0;
    emit_end   = 1'b0;
    emit_drop  = 1'b0;

    if (overlong) begin
      // close an open fragment with a byteless drop result
      if (parse_phase == ttrd_pkg::PH_FRAG) begin
        emit      = 1'b1;
        emit_drop = 1'b1;
      end
      parse_phase_next = ttrd_pkg::PH_SKIP;
    end else begin
      case (parse_phase)
        ttrd_pkg::PH_ETH: begin
          if (byte_position == ttrd_pkg::ETH_TYPE_HI_POS) begin
            ether_type_next = {b, 8'd0};
          end else if (byte_position == ttrd_pkg::ETH_TYPE_LO_POS) begin
            ether_type_next = {ether_type[15:8], b};
            if ({ether_type[15:8], b} == ttrd_pkg::ETH_TYPE_VLAN) begin
              parse_phase_next = ttrd_pkg::PH_VLAN;
            end else if ({ether_type[15:8], b} == ttrd_pkg::ETH_TYPE_IPV4) begin
              parse_phase_next = ttrd_pkg::PH_IP;
              layer_start_next = ttrd_pkg::IP_START_PLAIN;
            end else begin
              parse_phase_next = ttrd_pkg::PH_SKIP;
            end
          end
        end
        ttrd_pkg::PH_VLAN: begin
          if (byte_position == ttrd_pkg::VLAN_TYPE_HI_POS) begin
            ether_type_next = {b, 8'd0};
          end else if (byte_position == ttrd_pkg::VLAN_TYPE_LO_POS) begin
            ether_type_next = {ether_type[15:8], b};
            if ({ether_type[15:8], b} == ttrd_pkg::ETH_TYPE_IPV4) begin
              parse_phase_next = ttrd_pkg::PH_IP;
              layer_start_next = ttrd_pkg::IP_START_VLAN;
            end else begin
              parse_phase_next = ttrd_pkg::PH_SKIP;
            end
          end
        end
        ttrd_pkg::PH_IP: begin
          if (rel == 16'd0) begin
            if (b[3:0] < ttrd_pkg::HDR_MIN_WORDS) begin
              parse_phase_next = ttrd_pkg::PH_SKIP;
            end else begin
              layer_header_length_next = {b[3:0], 2'b00};
            end
          end else if (rel == ttrd_pkg::IP_PROTO_POS && b != ttrd_pkg::PROTO_TCP) begin
            parse_phase_next = ttrd_pkg::PH_SKIP;
          end else if (rel >= ttrd_pkg::HDR_MIN_LAST &&
                       rel_inc == {11'd0, layer_header_length}) begin
            parse_phase_next         = ttrd_pkg::PH_TCP;
            layer_start_next         = byte_position + 16'd1;
            layer_header_length_next = 6'd0;
          end
        end
        ttrd_pkg::PH_TCP: begin
          if (rel == ttrd_pkg::TCP_OFFSET_POS) begin
            if (b[7:4] < ttrd_pkg::HDR_MIN_WORDS) begin
              parse_phase_next = ttrd_pkg::PH_SKIP;
            end else begin
              layer_header_length_next = {b[7:4], 2'b00};
            end
          end else if (rel >= ttrd_pkg::HDR_MIN_LAST &&
                       rel_inc == {11'd0, layer_header_length}) begin
            parse_phase_next         = ttrd_pkg::PH_RHDR;
            record_header_count_next = 3'd0;
          end
        end
        ttrd_pkg::PH_RHDR: begin
          if (record_header_count == 3'd0) begin
            if (!(b inside {[ttrd_pkg::TLS_TYPE_MIN:ttrd_pkg::TLS_TYPE_MAX]})) begin
              parse_phase_next = ttrd_pkg::PH_SKIP;
            end else begin
              record_type_next         = b[4:0];
              record_header_bytes_next = 32'd0;
              record_header_count_next = 3'd1;
            end
          end else begin
            record_header_bytes_next = hdr_shift;
            record_header_count_next = record_header_count + 3'd1;
            if (record_header_count == ttrd_pkg::RHDR_LAST_COUNT) begin
              record_header_count_next = 3'd0;
              fragment_remaining_next  = hdr_shift[15:0];
              if (hdr_shift[15:0] == 16'd0) begin
                emit       = 1'b1;
                emit_first = 1'b1;
                emit_end   = 1'b1;
              end else begin
                parse_phase_next = ttrd_pkg::PH_FRAG;
              end
            end
          end
        end
        ttrd_pkg::PH_FRAG: begin
          emit       = 1'b1;
          emit_byte  = b;
          emit_valid = 1'b1;
          emit_first = fragment_remaining == record_header_bytes[15:0];
          emit_end   = fragment_remaining == 16'd1;
          emit_drop  = frame_item.packet_last && (fragment_remaining != 16'd1);
          fragment_remaining_next = fragment_remaining - 16'd1;
          if (fragment_remaining == 16'd1) begin
            parse_phase_next         = ttrd_pkg::PH_RHDR;
            record_header_count_next = 3'd0;
          end
        end
        default: begin
        end
      endcase
      byte_position_next = byte_position + 16'd1;
    end

    result.fragment_byte  = emit_byte;
    result.byte_valid     = emit_valid;
    result.tls_type       = record_type_next;
    result.record_version = record_header_bytes_next[31:16];
    result.record_length  = record_header_bytes_next[15:0];
    result.record_first   = emit_first;
    result.record_end     = emit_end;
    result.record_drop    = emit_drop;

    // frame end returns all per-packet state to its reset value
    if (frame_item.packet_last) begin
      parse_phase_next         = ttrd_pkg::PH_ETH;
      byte_position_next       = 16'd0;
      ether_type_next          = 16'd0;
      layer_start_next         = 16'd0;
      layer_header_length_next = 6'd0;
      record_header_bytes_next = 32'd0;
      record_header_count_next = 3'd0;
      fragment_remaining_next  = 16'd0;
      record_type_next         = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= ttrd_pkg::PH_ETH;
      byte_position       <= 16'd0;
      ether_type          <= 16'd0;
      layer_start         <= 16'd0;
      layer_header_length <= 6'd0;
      record_header_bytes <= 32'd0;
      record_header_count <= 3'd0;
      fragment_remaining  <= 16'd0;
      record_type         <= 5'd0;
    end else if (accept) begin
      parse_phase         <= parse_phase_next;
      byte_position       <= byte_position_next;
      ether_type          <= ether_type_next;
      layer_start         <= layer_start_next;
      layer_header_length <= layer_header_length_next;
      record_header_bytes <= record_header_bytes_next;
      record_header_count <= record_header_count_next;
      fragment_remaining  <= fragment_remaining_next;
      record_type         <= record_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!record_valid || !record_stall) begin
      // output register frees up: refill from skid first, else from the new byte
      if (skid_valid) begin
        record_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        record_valid <= accept && emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!record_valid || !record_stall) begin
      record_item <= skid_valid ? skid_item : result;
    end
    if (record_valid && record_stall && accept && emit) begin
      skid_item <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> record_valid)
    else $error("skid register full while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(record_valid && record_stall))
    else $error("skid register filled without a stalled output");

  a_empty_record_shape: assert property (@(posedge clk) disable iff (rst)
    (record_valid && !record_item.byte_valid && !record_item.record_drop)
      |-> (record_item.record_first && record_item.record_end))
    else $error("byteless result that is neither empty record nor drop");

  a_end_drop_exclusive: assert property (@(posedge clk) disable iff (rst)
    record_valid |-> !(record_item.record_end && record_item.record_drop))
    else $error("record marked both complete and dropped");
`endif

endmodule
